/* design/assert_macros.svh */
// Assertion macros shared by the evaluator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("%m: assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("%m: forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

/* design/rpn_pkg.sv */
// Shared types, character codes and status codes of the RPN evaluator.
package rpn_pkg;

    localparam int STACK_DEPTH_DEF = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BADCHAR    = 3'd1;
    localparam logic [2:0] ST_MULTIDIGIT = 3'd2;
    localparam logic [2:0] ST_UNDERFLOW  = 3'd3;
    localparam logic [2:0] ST_DIVZERO    = 3'd4;
    localparam logic [2:0] ST_FINALDEPTH = 3'd5;
    localparam logic [2:0] ST_OVERFLOW   = 3'd6;

    typedef enum logic [1:0] {
        CLS_SPACE,
        CLS_DIGIT,
        CLS_OP,
        CLS_OTHER
    } t_cls;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

    // Controller to datapath
    typedef struct packed {
        logic       load_in;
        logic       push;
        logic       set_prev;
        logic       clr_prev;
        logic       set_err;
        logic [2:0] err_code;
        logic       rd_left;
        logic       alu_wr;
        logic       unit_start;
        logic       unit_wr;
        logic       out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic err_held;
        t_cls cls;
        t_op  op;
        logic prev_digit;
        logic full;
        logic few;
        logic rhs_zero;
        logic unit_done;
        logic out_free;
    } t_sts;

endpackage

/* design/rpn_mdu.sv */
// Shared bit-serial multiply and signed divide unit, one bit per cycle.
`include "assert_macros.svh"

module rpn_mdu #(
    parameter int VALUE_WIDTH = rpn_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_div,
    input  logic [VALUE_WIDTH-1:0] i_a,
    input  logic [VALUE_WIDTH-1:0] i_b,
    output logic                   o_done,
    output logic [VALUE_WIDTH-1:0] o_result
);

    localparam int VW  = VALUE_WIDTH;
    localparam int CNW = $clog2(VALUE_WIDTH);

    logic           r_busy;
    logic           r_post;
    logic           r_done;
    logic [CNW-1:0] r_cnt;
    logic           r_div;
    logic           r_neg;
    logic [VW-1:0]  r_acc;
    logic [VW-1:0]  r_x;
    logic [VW-1:0]  r_y;
    logic [VW-1:0]  r_result;

    logic [VW-1:0]  w_abs_a;
    logic [VW-1:0]  w_abs_b;
    logic [VW:0]    w_sh;
    logic [VW:0]    w_diff;
    logic           w_ge;

    assign w_abs_a = i_a[VW-1] ? (~i_a + VW'(1)) : i_a;
    assign w_abs_b = i_b[VW-1] ? (~i_b + VW'(1)) : i_b;
    // restoring division step: shift in next dividend bit, trial subtract
    assign w_sh    = {r_acc, r_x[VW-1]};
    assign w_diff  = w_sh - {1'b0, r_y};
    assign w_ge    = !w_diff[VW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_post <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_post <= 1'b1;
            end else if (r_post) begin
                r_post <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CNW'(VW - 1);
            r_div <= i_div;
            r_neg <= i_a[VW-1] ^ i_b[VW-1];
            r_acc <= '0;
            r_x   <= i_div ? w_abs_a : i_a;
            r_y   <= i_div ? w_abs_b : i_b;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNW'(1);
            if (r_div) begin
                r_acc <= w_ge ? w_diff[VW-1:0] : w_sh[VW-1:0];
                r_x   <= {r_x[VW-2:0], w_ge};
            end else begin
                if (r_y[0]) begin
                    r_acc <= r_acc + r_x;
                end
                r_x <= {r_x[VW-2:0], 1'b0};
                r_y <= {1'b0, r_y[VW-1:1]};
            end
        end
        if (r_post) begin
            if (r_div) begin
                r_result <= r_neg ? (~r_x + VW'(1)) : r_x;
            end else begin
                r_result <= r_acc;
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    `ASSERT_NEVER(a_start_busy, i_clk, i_rst_n, i_start && (r_busy || r_post))

endmodule

/* design/rpn_dpath.sv */
// Evaluator datapath: stack memory, top register, error state and output register.
`include "assert_macros.svh"

module rpn_dpath #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH = rpn_pkg::VALUE_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rpn_pkg::t_cmd       i_cmd,
    output rpn_pkg::t_sts       o_sts,
    input  logic [7:0]          i_ch,
    input  logic                i_last_char,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [2:0]          o_status,
    output logic signed [31:0]  o_top_value,
    output logic [5:0]          o_depth,
    output logic                o_done_res
);

    localparam int VW = VALUE_WIDTH;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    // stack entries below the top; the top itself lives in r_top
    logic [VW-1:0] r_mem [STACK_DEPTH];
    logic [VW-1:0] r_left;
    logic [VW-1:0] r_top;
    logic [CW-1:0] r_count;
    logic          r_prev;
    logic [2:0]    r_err;
    logic [7:0]    r_ch;
    logic          r_last;

    logic                r_out_valid;
    logic [2:0]          r_status;
    logic signed [31:0]  r_top_o;
    logic [5:0]          r_depth;
    logic                r_done;

    logic [AW-1:0]      w_wr_addr;
    logic [AW-1:0]      w_rd_addr;
    logic [VW-1:0]      w_digit;
    logic [VW-1:0]      w_alu;
    logic [VW-1:0]      w_unit;
    logic               w_unit_done;
    logic signed [63:0] w_top_ext;
    logic [2:0]         w_status;
    rpn_pkg::t_cls      w_cls;
    rpn_pkg::t_op       w_op;

    assign w_wr_addr = AW'(r_count - CW'(1));
    assign w_rd_addr = AW'(r_count - CW'(2));
    assign w_digit   = VW'(r_ch - rpn_pkg::CH_ZERO);
    assign w_alu     = (w_op == rpn_pkg::OP_SUB) ? (r_left - r_top) : (r_left + r_top);
    assign w_top_ext = 64'(signed'(r_top));

    always_comb begin
        w_op = rpn_pkg::OP_ADD;
        if (r_ch == rpn_pkg::CH_SPACE) begin
            w_cls = rpn_pkg::CLS_SPACE;
        end else if (r_ch >= rpn_pkg::CH_ZERO && r_ch <= rpn_pkg::CH_NINE) begin
            w_cls = rpn_pkg::CLS_DIGIT;
        end else if (r_ch == rpn_pkg::CH_PLUS) begin
            w_cls = rpn_pkg::CLS_OP;
        end else if (r_ch == rpn_pkg::CH_MINUS) begin
            w_cls = rpn_pkg::CLS_OP;
            w_op  = rpn_pkg::OP_SUB;
        end else if (r_ch == rpn_pkg::CH_STAR) begin
            w_cls = rpn_pkg::CLS_OP;
            w_op  = rpn_pkg::OP_MUL;
        end else if (r_ch == rpn_pkg::CH_SLASH) begin
            w_cls = rpn_pkg::CLS_OP;
            w_op  = rpn_pkg::OP_DIV;
        end else begin
            w_cls = rpn_pkg::CLS_OTHER;
        end
    end

    always_comb begin
        w_status = r_err;
        if (r_last && r_err == rpn_pkg::ST_OK && r_count != CW'(1)) begin
            w_status = rpn_pkg::ST_FINALDEPTH;
        end
    end

    rpn_mdu #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_mdu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.unit_start),
        .i_div    (w_op == rpn_pkg::OP_DIV),
        .i_a      (r_left),
        .i_b      (r_top),
        .o_done   (w_unit_done),
        .o_result (w_unit)
    );

    always_comb begin
        o_sts.err_held   = (r_err != rpn_pkg::ST_OK);
        o_sts.cls        = w_cls;
        o_sts.op         = w_op;
        o_sts.prev_digit = r_prev;
        o_sts.full       = (r_count >= CW'(STACK_DEPTH));
        o_sts.few        = (r_count < CW'(2));
        o_sts.rhs_zero   = (r_top == '0);
        o_sts.unit_done  = w_unit_done;
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    // stack memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && r_count != '0) begin
            r_mem[w_wr_addr] <= r_top;
        end
        if (i_cmd.rd_left) begin
            r_left <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_prev      <= 1'b0;
            r_err       <= rpn_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.set_prev) begin
                r_prev <= 1'b1;
            end
            if (i_cmd.clr_prev) begin
                r_prev <= 1'b0;
            end
            if (i_cmd.set_err) begin
                r_err <= i_cmd.err_code;
            end
            if (i_cmd.push) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.alu_wr || i_cmd.unit_wr) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
                if (r_last) begin
                    r_count <= '0;
                    r_prev  <= 1'b0;
                    r_err   <= rpn_pkg::ST_OK;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_ch   <= i_ch;
            r_last <= i_last_char;
        end
        if (i_cmd.push) begin
            r_top <= w_digit;
        end else if (i_cmd.alu_wr) begin
            r_top <= w_alu;
        end else if (i_cmd.unit_wr) begin
            r_top <= w_unit;
        end
        if (i_cmd.out_load) begin
            r_status <= w_status;
            r_top_o  <= (r_count != '0) ? w_top_ext[31:0] : '0;
            r_depth  <= 6'(r_count);
            r_done   <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_top_value = r_top_o;
    assign o_depth     = r_depth;
    assign o_done_res  = r_done;

    `ASSERT_CLK(a_count_range, i_clk, i_rst_n, r_count <= CW'(STACK_DEPTH))
    `ASSERT_NEVER(a_push_pop, i_clk, i_rst_n, i_cmd.push && (i_cmd.alu_wr || i_cmd.unit_wr))
    `ASSERT_CLK(a_clear_last, i_clk, i_rst_n, i_cmd.out_load && r_last |=> r_count == '0)

endmodule

/* design/rpn_ctrl.sv */
// Evaluator sequencer: decodes each character and steps the datapath.
module rpn_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rpn_pkg::t_sts i_sts,
    output rpn_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LOAD,
        S_WAIT,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_FINISH;
                if (!i_sts.err_held) begin
                    case (i_sts.cls)
                        rpn_pkg::CLS_SPACE: begin
                            o_cmd.clr_prev = 1'b1;
                        end
                        rpn_pkg::CLS_DIGIT: begin
                            if (i_sts.prev_digit) begin
                                o_cmd.set_err  = 1'b1;
                                o_cmd.err_code = rpn_pkg::ST_MULTIDIGIT;
                            end else if (i_sts.full) begin
                                o_cmd.set_err  = 1'b1;
                                o_cmd.err_code = rpn_pkg::ST_OVERFLOW;
                            end else begin
                                o_cmd.push     = 1'b1;
                                o_cmd.set_prev = 1'b1;
                            end
                        end
                        rpn_pkg::CLS_OP: begin
                            o_cmd.clr_prev = 1'b1;
                            if (i_sts.few) begin
                                o_cmd.set_err  = 1'b1;
                                o_cmd.err_code = rpn_pkg::ST_UNDERFLOW;
                            end else begin
                                o_cmd.rd_left = 1'b1;
                                n_state       = S_LOAD;
                            end
                        end
                        default: begin
                            o_cmd.set_err  = 1'b1;
                            o_cmd.err_code = rpn_pkg::ST_BADCHAR;
                        end
                    endcase
                end
            end
            S_LOAD: begin
                n_state = S_FINISH;
                case (i_sts.op)
                    rpn_pkg::OP_ADD, rpn_pkg::OP_SUB: begin
                        o_cmd.alu_wr = 1'b1;
                    end
                    rpn_pkg::OP_DIV: begin
                        if (i_sts.rhs_zero) begin
                            o_cmd.set_err  = 1'b1;
                            o_cmd.err_code = rpn_pkg::ST_DIVZERO;
                        end else begin
                            o_cmd.unit_start = 1'b1;
                            n_state          = S_WAIT;
                        end
                    end
                    default: begin
                        o_cmd.unit_start = 1'b1;
                        n_state          = S_WAIT;
                    end
                endcase
            end
            S_WAIT: begin
                if (i_sts.unit_done) begin
                    o_cmd.unit_wr = 1'b1;
                    n_state       = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

/* design/rpn_stack_evaluator.sv */
// Top level of the reverse Polish notation evaluator.
//
// Input channel (i_in_valid / o_in_ready): one ASCII character per transfer,
// with i_last_char marking the final character of an expression. Digits push
// their value, + - * / pop two values and push the result, space is skipped.
// Output channel (o_out_valid / i_out_ready): exactly one result per input
// character: sticky status, stack top (sign extended), depth, and o_done_res
// on the last character of an expression.
// From input transfer to output valid, a digit, a space, an operator short of
// operands or any character after an error passes the decode and finish steps;
// + and - and / with a zero divisor add an operand load step; * and other / also
// wait on the bit-serial multiply/divide unit that retires one bit per cycle.
// One character is in work at a time and the sequencer returns to idle to take
// the next. A new character is taken while the previous result still waits in
// the output register.
// Reset (synchronous, active low) empties the stack and clears the error and
// output valid; stack memory itself is not cleared and needs no sweep.
// If the receiver stalls, the finished result holds in the output register
// and the next character waits in its final step until that register frees.
module rpn_stack_evaluator #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH = rpn_pkg::VALUE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_ch,
    input  logic               i_last_char,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_top_value,
    output logic [5:0]         o_depth,
    output logic               o_done_res
);

    rpn_pkg::t_cmd w_cmd;
    rpn_pkg::t_sts w_sts;

    // sequencer: one character at a time, drives datapath commands
    rpn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // stack, arithmetic and the output register
    rpn_dpath #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_ch        (i_ch),
        .i_last_char (i_last_char),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_status    (o_status),
        .o_top_value (o_top_value),
        .o_depth     (o_depth),
        .o_done_res  (o_done_res)
    );

endmodule

/* test/rpn_stack_evaluator_chk.sv */
// Scoreboard of the RPN evaluator: predicts every result and compares it.
module rpn_stack_evaluator_chk
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_ch,
    input  logic        i_last_char,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_status,
    input  logic [31:0] i_top_value,
    input  logic [5:0]  i_depth,
    input  logic        i_done_res,
    output int          o_mismatches,
    output int          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] top_value;
        logic [5:0]  depth;
        logic        done;
    } t_eval_result;

    // Shadow of the evaluator state
    logic [31:0]  stack_vals [STACK_DEPTH];
    int           stack_cnt;
    logic         prev_digit;
    logic [2:0]   held_err;
    t_eval_result eval_results_q [$];
    int           mismatch_cnt;

    initial begin
        mismatch_cnt  = 0;
        stack_cnt     = 0;
        prev_digit    = 1'b0;
        held_err      = ST_OK;
    end

    // Apply one character to the shadow stack and return what the block reports.
    function automatic t_eval_result evaluate_char(input logic [7:0] c, input logic last);
        t_eval_result r;
        logic [31:0]  lhs;
        logic [31:0]  rhs;
        logic [31:0]  lmag;
        logic [31:0]  rmag;
        logic [31:0]  res;
        if (held_err == ST_OK) begin
            if (c == CH_SPACE) begin
                prev_digit = 1'b0;
            end else if (c >= CH_ZERO && c <= CH_NINE) begin
                if (prev_digit) begin
                    held_err = ST_MULTIDIGIT;
                end else if (stack_cnt >= STACK_DEPTH) begin
                    held_err = ST_OVERFLOW;
                end else begin
                    stack_vals[stack_cnt] = 32'(c - CH_ZERO);
                    stack_cnt++;
                    prev_digit = 1'b1;
                end
            end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
                prev_digit = 1'b0;
                if (stack_cnt < 2) begin
                    held_err = ST_UNDERFLOW;
                end else begin
                    rhs = stack_vals[stack_cnt-1];
                    lhs = stack_vals[stack_cnt-2];
                    if (c == CH_SLASH && rhs == '0) begin
                        held_err = ST_DIVZERO;
                    end else begin
                        case (c)
                            CH_PLUS:  res = lhs + rhs;
                            CH_MINUS: res = lhs - rhs;
                            CH_STAR:  res = lhs * rhs;
                            default: begin
                                // divide magnitudes so the most negative value wraps
                                lmag = lhs[31] ? -lhs : lhs;
                                rmag = rhs[31] ? -rhs : rhs;
                                res  = lmag / rmag;
                                if (lhs[31] ^ rhs[31]) res = -res;
                            end
                        endcase
                        stack_vals[stack_cnt-2] = res;
                        stack_cnt--;
                    end
                end
            end else begin
                held_err = ST_BADCHAR;
            end
        end
        r.status = held_err;
        if (last && held_err == ST_OK && stack_cnt != 1) r.status = ST_FINALDEPTH;
        r.top_value = (stack_cnt > 0) ? stack_vals[stack_cnt-1] : '0;
        r.depth     = 6'(stack_cnt);
        r.done      = last;
        if (last) begin
            stack_cnt  = 0;
            prev_digit = 1'b0;
            held_err   = ST_OK;
        end
        return r;
    endfunction

    task automatic flag_result(input string why, input t_eval_result want,
                               input t_eval_result got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $write("%0t: %s: expected status %0d top %0d depth %0d done %0b, ",
                   $time, why, want.status, $signed(want.top_value), want.depth, want.done);
            $display("got status %0d top %0d depth %0d done %0b",
                     got.status, $signed(got.top_value), got.depth, got.done);
        end
    endtask

    always @(posedge i_clk) begin
        t_eval_result got;
        t_eval_result want;
        if (!i_rst_n) begin
            eval_results_q.delete();
            stack_cnt  = 0;
            prev_digit = 1'b0;
            held_err   = ST_OK;
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = '{i_status, i_top_value, i_depth, i_done_res};
                if (eval_results_q.size() == 0) begin
                    flag_result("result with nothing expected", '0, got);
                end else begin
                    want = eval_results_q.pop_front();
                    if (got.status !== want.status || got.top_value !== want.top_value ||
                        got.depth !== want.depth || got.done !== want.done)
                        flag_result("result mismatch", want, got);
                end
            end
            if (i_in_valid && i_in_ready)
                eval_results_q.push_back(evaluate_char(i_ch, i_last_char));
        end
        o_outstanding <= eval_results_q.size();
        o_mismatches  <= mismatch_cnt;
    end

endmodule

/* test/rpn_stack_evaluator_tb.sv */
// Top of the RPN evaluator testbench: stimulus, handshake idling and verdict.
module rpn_stack_evaluator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rpn_pkg::*;

    localparam int STACK_DEPTH  = STACK_DEPTH_DEF;
    localparam int VALUE_WIDTH  = VALUE_WIDTH_DEF;
    // Slowest character (multiply or divide) plus margin for a trailing stall
    localparam int DRAIN_CYCLES = VALUE_WIDTH + 70;
    localparam int RANDOM_ITEMS = 1000;
    // Roughly 1150 characters, each at worst a full-width divide, a long
    // sender gap and a long receiver stall, taken five times over
    localparam int CYCLE_LIMIT  = 1_000_000;

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    logic [7:0]         i_ch        = CH_SPACE;
    logic               i_last_char = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [2:0]         o_status;
    logic signed [31:0] o_top_value;
    logic [5:0]         o_depth;
    logic               o_done_res;

    int mismatches;
    int outstanding;

    // Characters of the expression being sent; the last one carries i_last_char
    logic [7:0] expr_q [$];
    int         items_sent = 0;
    bit         in_quiet   = 1'b0;
    int         cycle_cnt  = 0;

    rpn_stack_evaluator #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_ch        (i_ch),
        .i_last_char (i_last_char),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_top_value (o_top_value),
        .o_depth     (o_depth),
        .o_done_res  (o_done_res)
    );

    rpn_stack_evaluator_chk #(
        .STACK_DEPTH (STACK_DEPTH)
    ) CHK (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_ch          (i_ch),
        .i_last_char   (i_last_char),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_status      (o_status),
        .i_top_value   (o_top_value),
        .i_depth       (o_depth),
        .i_done_res    (o_done_res),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Receiver side: random stalls, with stretches of steady ready mixed in
    always @(posedge i_clk) begin
        int  stall_left;
        int  run_left;
        bit  out_quiet;
        if (run_left <= 0) begin
            run_left  = $urandom_range(50, 400);
            out_quiet = ($urandom_range(0, 3) == 0);
        end
        run_left--;
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            i_out_ready <= 1'b1;
            stall_left = out_quiet ? 0 : pick_gap();
        end
    end

    // Transfer one character: idle for a random gap, then hold valid and
    // payload steady until the block takes it. Valid is not dropped between
    // back-to-back transfers.
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = in_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_ch        <= c;
        i_last_char <= last;
        do @(posedge i_clk); while (!o_in_ready);
        if (c != CH_SPACE) items_sent++;
    endtask

    // Send the queued expression, marking its final character
    task automatic send_expr();
        if ($urandom_range(0, 19) == 0) in_quiet = ~in_quiet;
        for (int i = 0; i < expr_q.size(); i++)
            send_char(expr_q[i], i == expr_q.size() - 1);
    endtask

    task automatic load_text(input string s);
        expr_q.delete();
        for (int i = 0; i < s.len(); i++) expr_q.push_back(s[i]);
    endtask

    // Build a well-formed expression with n_digits operands. Push all operands
    // first when left_deep is set, so the stack grows as deep as n_digits.
    task automatic build_expr(input int n_digits, input bit left_deep);
        int depth;
        int pushed;
        bit after_digit;
        bit push_now;
        expr_q.delete();
        depth       = 0;
        pushed      = 0;
        after_digit = 1'b0;
        while (pushed < n_digits || depth > 1) begin
            push_now = (pushed < n_digits) &&
                       (depth < 2 || left_deep || $urandom_range(0, 1) == 1);
            if (push_now) begin
                // separate adjacent digits, otherwise space now and then
                if (after_digit || $urandom_range(0, 4) == 0) expr_q.push_back(CH_SPACE);
                expr_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                depth++;
                pushed++;
                after_digit = 1'b1;
            end else begin
                if ($urandom_range(0, 4) == 0) expr_q.push_back(CH_SPACE);
                case (t_op'($urandom_range(0, 3)))
                    OP_ADD:  expr_q.push_back(CH_PLUS);
                    OP_SUB:  expr_q.push_back(CH_MINUS);
                    OP_MUL:  expr_q.push_back(CH_STAR);
                    default: expr_q.push_back(CH_SLASH);
                endcase
                depth--;
                after_digit = 1'b0;
            end
        end
        if ($urandom_range(0, 9) == 0) expr_q.push_back(CH_SPACE);
    endtask

    // Break a well-formed expression: drop, insert, overwrite or cut short
    task automatic mutate_expr();
        int pos;
        pos = $urandom_range(0, expr_q.size() - 1);
        case ($urandom_range(0, 3))
            0: if (expr_q.size() > 1) expr_q.delete(pos);
            1: expr_q.insert(pos, 8'($urandom_range(0, 255)));
            2: expr_q[pos] = CH_ZERO + 8'($urandom_range(0, 9));
            default: while (expr_q.size() > pos + 1) void'(expr_q.pop_back());
        endcase
    endtask

    initial begin
        int kind;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part.
        // 8^10 * 2 wraps to the most negative value; divide it by -1
        load_text("8 8*8*8*8*8*8*8*8*8*2*0 1-/");
        send_expr();
        // -7 / 2 truncates toward zero, then add 9
        load_text("0 7-2/9+");
        send_expr();
        // too few operands, raised on the final character
        load_text("5+");
        send_expr();
        // adjacent digits
        load_text("12");
        send_expr();
        // zero divisor
        load_text("4 0/");
        send_expr();
        // unknown character mid-expression, later characters ignored
        load_text("3 #4+");
        send_expr();
        expr_q = '{8'hFF, 8'h00};
        send_expr();
        // final depth two, and final depth zero
        load_text("1 2");
        send_expr();
        load_text(" ");
        send_expr();
        // fill the stack, then push one more
        expr_q.delete();
        for (int k = 0; k <= STACK_DEPTH; k++) begin
            if (k > 0) expr_q.push_back(CH_SPACE);
            expr_q.push_back(CH_NINE);
        end
        send_expr();

        // Random part: mostly well-formed expressions with random content,
        // some deep ones that fill the stack, the rest broken or pure noise.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                build_expr($urandom_range(1, 6), 1'b0);
            end else if (kind < 65) begin
                build_expr($urandom_range(7, 16), 1'($urandom_range(0, 1)));
            end else if (kind < 68) begin
                build_expr($urandom_range(28, STACK_DEPTH + 2), 1'b1);
            end else if (kind < 85) begin
                build_expr($urandom_range(1, 8), 1'b0);
                mutate_expr();
            end else begin
                expr_q.delete();
                repeat ($urandom_range(1, 5)) expr_q.push_back(8'($urandom_range(0, 255)));
            end
            send_expr();
        end
        i_in_valid <= 1'b0;

        // Drain: wait until every expected result has arrived, then watch for strays
        do @(posedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/rpn_pkg.sv
design/rpn_mdu.sv
design/rpn_dpath.sv
design/rpn_ctrl.sv
design/rpn_stack_evaluator.sv
test/rpn_stack_evaluator_chk.sv
test/rpn_stack_evaluator_tb.sv
